// File: sv/mvc_pkg.sv
// mvc_pkg: shared types, command codes and exp2 table builder for the voice unit.
// Standalone package; used by mvc_ctrl, mvc_datapath and mpe_voice_control_unit.
package mvc_pkg;

    typedef enum logic [2:0] {
        CMD_NOTE_ON  = 3'd0,
        CMD_NOTE_OFF = 3'd1,
        CMD_GLIDE    = 3'd2,
        CMD_SLIDE    = 3'd3,
        CMD_PRESS    = 3'd4,
        CMD_TICK     = 3'd5,
        CMD_CLEAR    = 3'd6
    } cmd_code_t;

    typedef enum logic [1:0] {
        CFG_SLEW_FACTOR = 2'd0,
        CFG_BEND_UP     = 2'd1,
        CFG_BEND_DOWN   = 2'd2
    } cfg_index_t;

    typedef struct packed {
        logic [2:0]         command;
        logic [6:0]         note;
        logic signed [15:0] value;
    } cmd_word_t;

    typedef struct packed {
        logic               gate;
        logic [21:0]        pitch_hz;
        logic signed [15:0] glide_now;
        logic signed [15:0] slide_now;
        logic signed [15:0] press_now;
        logic signed [15:0] strike_level;
        logic signed [15:0] lift_level;
        logic [31:0]        voice_age;
    } rsp_word_t;

    // datapath operations, one per controller step
    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_SLEW_G,
        OP_SLEW_S,
        OP_SLEW_P,
        OP_SLEW_END,
        OP_BEND,
        OP_POS,
        OP_IDX,
        OP_TBL,
        OP_MIX,
        OP_DIV,
        OP_SCALE,
        OP_ROUND,
        OP_SNAP
    } dp_op_t;

    typedef struct packed {
        logic   take;
        dp_op_t op;
    } dp_ctrl_t;

    typedef struct packed {
        logic [2:0] code;
    } dp_stat_t;

    function automatic logic [63:0] isqrt64(logic [63:0] v_in);
        logic [63:0] v;
        logic [63:0] r;
        logic [63:0] b;
        v = v_in;
        r = 64'd0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 64'd0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
            begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    // Q30 value of 2^(idx/2^bits), built from repeated square roots of two
    function automatic logic [31:0] exp_entry(int idx, int bits);
        logic [63:0] roots [12];
        logic [63:0] v;
        roots[0] = isqrt64(64'd1 << 61);
        for (int j = 1; j < 12; j++)
            roots[j] = (j < bits) ? isqrt64(roots[j-1] << 30) : 64'd0;
        v = 64'd1 << 30;
        for (int k = 0; k < bits; k++)
            if (((idx >> k) & 1) == 1)
                v = (v * roots[bits-1-k] + (64'd1 << 29)) >> 30;
        if (idx == (1 << bits))
            v = 64'd1 << 31;
        return v[31:0];
    endfunction

endpackage

// File: sv/mpe_voice_control_unit.sv
// mpe_voice_control_unit: top level of one per-note-expression synth voice.
// Depends on mvc_pkg, mvc_ctrl and mvc_datapath.

// One command word is taken at a time. Note off, target, clear and unknown
// commands go from the load step straight to the snapshot step; note on adds
// the bend, position, index, table, mix, divide, scale and round steps, and
// tick runs the three slews and their write-back before those. The steps
// follow from the single shared 33x33 multiplier, which does the three slews,
// the bend product, the exp2 interpolation, the divide by 3072 and the final
// Hz scale one after another, plus position, index, table and rounding steps.
// The next command can be taken once the previous one is in the result
// register, even while that result is still stalled. Config writes are always
// ready and must only be issued while the unit is idle; index 3 is ignored.
// Pitch is 440 * 2^((root + bend - 69)/12) in Q14.8 Hz through a 2^B+1 entry
// Q30 exp2 table with linear interpolation; positions above note 127 give 0.
module mpe_voice_control_unit #(
    parameter int AGE_BITS       = 32,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cmd_valid,
    output logic               cmd_stall,
    input  mvc_pkg::cmd_word_t cmd_word,
    output logic               rsp_valid,
    input  logic               rsp_stall,
    output mvc_pkg::rsp_word_t rsp_word,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data
);
    import mvc_pkg::*;

    dp_ctrl_t ctrl;
    dp_stat_t stat;

    assign cfg_ready = 1'b1;

    mvc_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .ctrl      (ctrl),
        .stat      (stat)
    );

    mvc_datapath #(
        .AGE_BITS       (AGE_BITS),
        .EXP_TABLE_BITS (EXP_TABLE_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_word  (cmd_word),
        .ctrl      (ctrl),
        .stat      (stat),
        .cfg_wr    (cfg_valid && cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .rsp_word  (rsp_word)
    );

endmodule

// File: sv/mvc_ctrl.sv
// mvc_ctrl: sequencer for the voice unit; steps the datapath through each command.
// Depends on mvc_pkg.
module mvc_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    output logic              cmd_stall,
    output logic              rsp_valid,
    input  logic              rsp_stall,
    output mvc_pkg::dp_ctrl_t ctrl,
    input  mvc_pkg::dp_stat_t stat
);
    import mvc_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE, S_LOAD, S_SLEW_G, S_SLEW_S, S_SLEW_P, S_SLEW_END, S_BEND,
        S_POS, S_IDX, S_TBL, S_MIX, S_DIV, S_SCALE, S_ROUND, S_SNAP
    } state_t;

    state_t state_reg, state_next;
    logic   rsp_valid_reg, rsp_valid_next;
    logic   slot_free;
    logic   snap;

    assign slot_free = !rsp_valid_reg || !rsp_stall;
    assign snap      = (state_reg == S_SNAP) && slot_free;
    assign cmd_stall = (state_reg != S_IDLE);
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        ctrl.take = (state_reg == S_IDLE) && cmd_valid;
        unique case (state_reg)
            S_IDLE:     ctrl.op = OP_NONE;
            S_LOAD:     ctrl.op = OP_LOAD;
            S_SLEW_G:   ctrl.op = OP_SLEW_G;
            S_SLEW_S:   ctrl.op = OP_SLEW_S;
            S_SLEW_P:   ctrl.op = OP_SLEW_P;
            S_SLEW_END: ctrl.op = OP_SLEW_END;
            S_BEND:     ctrl.op = OP_BEND;
            S_POS:      ctrl.op = OP_POS;
            S_IDX:      ctrl.op = OP_IDX;
            S_TBL:      ctrl.op = OP_TBL;
            S_MIX:      ctrl.op = OP_MIX;
            S_DIV:      ctrl.op = OP_DIV;
            S_SCALE:    ctrl.op = OP_SCALE;
            S_ROUND:    ctrl.op = OP_ROUND;
            S_SNAP:     ctrl.op = snap ? OP_SNAP : OP_NONE;
            default:    ctrl.op = OP_NONE;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:     if (ctrl.take) state_next = S_LOAD;
            S_LOAD:
            begin
                unique case (stat.code)
                    CMD_NOTE_ON: state_next = S_BEND;
                    CMD_TICK:    state_next = S_SLEW_G;
                    default:     state_next = S_SNAP;
                endcase
            end
            S_SLEW_G:   state_next = S_SLEW_S;
            S_SLEW_S:   state_next = S_SLEW_P;
            S_SLEW_P:   state_next = S_SLEW_END;
            S_SLEW_END: state_next = S_BEND;
            S_BEND:     state_next = S_POS;
            S_POS:      state_next = S_IDX;
            S_IDX:      state_next = S_TBL;
            S_TBL:      state_next = S_MIX;
            S_MIX:      state_next = S_DIV;
            S_DIV:      state_next = S_SCALE;
            S_SCALE:    state_next = S_ROUND;
            S_ROUND:    state_next = S_SNAP;
            S_SNAP:     if (snap) state_next = S_IDLE;
            default:    state_next = S_IDLE;
        endcase
        if (snap)
            rsp_valid_next = 1'b1;
        else
            rsp_valid_next = rsp_valid_reg && rsp_stall;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    a_take_loads: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_stall |=> state_reg == S_LOAD)
        else $error("accepted word did not start a load");

    a_snap_valid: assert property (@(posedge clk) disable iff (!rst_n)
        snap |=> rsp_valid_reg)
        else $error("snapshot taken without raising result valid");

    a_tick_slews: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOAD && stat.code == CMD_TICK |=> state_reg == S_SLEW_G)
        else $error("tick did not enter the slew sequence");

endmodule

// File: sv/mvc_datapath.sv
// mvc_datapath: voice state, config registers, shared multiplier, exp2 table.
// Depends on mvc_pkg; driven by mvc_ctrl.
module mvc_datapath #(
    parameter int AGE_BITS       = 32,
    parameter int EXP_TABLE_BITS = 8
) (
    input  logic               clk,
    input  logic               rst_n,
    input  mvc_pkg::cmd_word_t cmd_word,
    input  mvc_pkg::dp_ctrl_t  ctrl,
    output mvc_pkg::dp_stat_t  stat,
    input  logic               cfg_wr,
    input  logic [1:0]         cfg_index,
    input  logic [15:0]        cfg_data,
    output mvc_pkg::rsp_word_t rsp_word
);
    import mvc_pkg::*;

    localparam int TBL_N = 1 << EXP_TABLE_BITS;
    localparam int TW    = 12 + EXP_TABLE_BITS;   // scaled remainder
    localparam int UW    = TW - 10;
    localparam int IW    = UW + 15;
    localparam int IXW   = EXP_TABLE_BITS + 1;

    logic [31:0] exp_tbl [TBL_N+1];

    for (genvar g = 0; g <= TBL_N; g++)
    begin : g_tbl
        assign exp_tbl[g] = exp_entry(g, EXP_TABLE_BITS);
    end

    // configuration
    logic [15:0] sf_reg;
    logic [13:0] up_reg, dn_reg;

    // voice state
    logic                gate_reg;
    logic [6:0]          root_reg;
    logic signed [15:0]  strike_reg, lift_reg;
    logic signed [15:0]  gc_reg, gt_reg, sc_reg, st_reg, pc_reg, pt_reg;
    logic [21:0]         pitch_reg;
    logic [AGE_BITS-1:0] age_reg;

    // working registers
    cmd_word_t                 item_reg;
    logic signed [65:0]        prod_reg;
    logic [16:0]               e_reg;
    logic [4:0]                k_reg;
    logic                      zero_reg;
    logic [EXP_TABLE_BITS-1:0] idx_reg;
    logic [11:0]               f_reg;
    logic [31:0]               ti_reg, ti1_reg;
    rsp_word_t                 rsp_reg;

    // combinational
    logic signed [32:0] mul_a, mul_b;
    logic signed [16:0] g_diff, s_diff, p_diff;
    logic signed [65:0] slew_sum, slew_step, bend_sum, bend_shift;
    logic [15:0]        step16;
    logic [13:0]        range;
    logic signed [17:0] pos, e_full;
    logic [12:0]        k_mul;
    logic [11:0]        rem;
    logic [TW-1:0]      t_val;
    logic [IW-1:0]      idx_mul;
    logic [EXP_TABLE_BITS-1:0] idx_val;
    logic [11:0]        f_val;
    logic [IXW-1:0]     idx_ix, idx_ix1;
    logic [65:0]        div_in;
    logic [31:0]        m_val;
    logic [5:0]         sh;
    logic [48:0]        half, xr;
    logic [21:0]        pitch_val;

    assign stat.code = item_reg.command;
    assign rsp_word  = rsp_reg;

    assign g_diff = 17'(gc_reg) - 17'(gt_reg);
    assign s_diff = 17'(sc_reg) - 17'(st_reg);
    assign p_diff = 17'(pc_reg) - 17'(pt_reg);
    assign range  = (gc_reg > 16'sd0) ? up_reg : dn_reg;

    // slew write-back: tgt + round(s*(cur-tgt) / 2^16)
    assign slew_sum  = prod_reg + 66'sd32768;
    assign slew_step = slew_sum >>> 16;
    assign step16    = slew_step[15:0];

    // bend and octave split
    assign bend_sum   = prod_reg + 66'sd16384;
    assign bend_shift = bend_sum >>> 15;
    assign pos    = $signed(18'({root_reg, 8'b0})) + bend_shift[17:0];
    assign e_full = pos + 18'sd22272;
    assign k_mul  = 13'(e_full[16:10]) * 13'd43;   // divide by 3 over seven bits

    // table index and fraction
    assign rem     = 12'(e_reg - 17'({k_reg, 11'b0}) - 17'({k_reg, 10'b0}));
    assign t_val   = TW'(rem) << EXP_TABLE_BITS;
    assign idx_mul = IW'(t_val[TW-1:10]) * IW'(21846);
    assign idx_val = idx_mul[16 +: EXP_TABLE_BITS];
    assign f_val   = 12'(t_val - (TW'(idx_val) << 11) - (TW'(idx_val) << 10));
    assign idx_ix  = IXW'(idx_reg);
    assign idx_ix1 = IXW'(idx_reg) + IXW'(1);

    assign div_in = prod_reg + 66'sd1536;
    assign m_val  = ti_reg + prod_reg[64:33];

    // final scale: round half up by 2^(30-q), saturate
    assign sh   = 6'd43 - 6'(k_reg);
    assign half = 49'd1 << (sh - 6'd1);
    assign xr   = (49'(prod_reg[47:0]) + half) >> sh;
    assign pitch_val = zero_reg ? 22'd0 :
                       (xr > 49'd4194303) ? 22'h3FFFFF : xr[21:0];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (ctrl.op)
            OP_SLEW_G:
            begin
                mul_a = $signed({17'b0, sf_reg});
                mul_b = 33'(g_diff);
            end
            OP_SLEW_S:
            begin
                mul_a = $signed({17'b0, sf_reg});
                mul_b = 33'(s_diff);
            end
            OP_SLEW_P:
            begin
                mul_a = $signed({17'b0, sf_reg});
                mul_b = 33'(p_diff);
            end
            OP_BEND:
            begin
                mul_a = 33'(gc_reg);
                mul_b = $signed({19'b0, range});
            end
            OP_MIX:
            begin
                mul_a = $signed({1'b0, ti1_reg - ti_reg});
                mul_b = $signed({21'b0, f_reg});
            end
            OP_DIV:
            begin
                mul_a = $signed({1'b0, div_in[41:10]});
                mul_b = $signed({1'b0, 32'hAAAA_AAAB});
            end
            OP_SCALE:
            begin
                mul_a = $signed({1'b0, m_val});
                mul_b = 33'sd112640;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sf_reg <= 16'd64880;
            up_reg <= 14'd512;
            dn_reg <= 14'd512;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_index)
                CFG_SLEW_FACTOR: sf_reg <= cfg_data;
                CFG_BEND_UP:     up_reg <= cfg_data[13:0];
                CFG_BEND_DOWN:   dn_reg <= cfg_data[13:0];
                default:         ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gate_reg   <= 1'b0;
            root_reg   <= '0;
            strike_reg <= '0;
            lift_reg   <= '0;
            gc_reg     <= '0;
            gt_reg     <= '0;
            sc_reg     <= '0;
            st_reg     <= '0;
            pc_reg     <= '0;
            pt_reg     <= '0;
            pitch_reg  <= '0;
            age_reg    <= '1;
        end
        else
        begin
            case (ctrl.op)
                OP_LOAD:
                begin
                    unique case (item_reg.command)
                        CMD_NOTE_ON:
                        begin
                            age_reg    <= '0;
                            gate_reg   <= 1'b1;
                            root_reg   <= item_reg.note;
                            strike_reg <= item_reg.value;
                        end
                        CMD_NOTE_OFF:
                        begin
                            if (gate_reg && item_reg.note == root_reg)
                            begin
                                gate_reg <= 1'b0;
                                lift_reg <= item_reg.value;
                            end
                        end
                        CMD_GLIDE: gt_reg <= item_reg.value;
                        CMD_SLIDE: st_reg <= item_reg.value;
                        CMD_PRESS: pt_reg <= item_reg.value;
                        CMD_TICK:
                        begin
                            if (age_reg != '1)
                                age_reg <= age_reg + 1'b1;
                        end
                        CMD_CLEAR:
                        begin
                            gate_reg   <= 1'b0;
                            strike_reg <= '0;
                            lift_reg   <= '0;
                            gc_reg     <= '0;
                            gt_reg     <= '0;
                            sc_reg     <= '0;
                            st_reg     <= '0;
                            pc_reg     <= '0;
                            pt_reg     <= '0;
                            pitch_reg  <= '0;
                            age_reg    <= '1;
                        end
                        default: ;
                    endcase
                end
                OP_SLEW_S:   gc_reg    <= gt_reg + step16;
                OP_SLEW_P:   sc_reg    <= st_reg + step16;
                OP_SLEW_END: pc_reg    <= pt_reg + step16;
                OP_ROUND:    pitch_reg <= pitch_val;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (ctrl.take)
            item_reg <= cmd_word;
        prod_reg <= mul_a * mul_b;
        if (ctrl.op == OP_POS)
        begin
            e_reg    <= e_full[16:0];
            k_reg    <= k_mul[11:7];
            zero_reg <= (pos > 18'sd32512);
        end
        if (ctrl.op == OP_IDX)
        begin
            idx_reg <= idx_val;
            f_reg   <= f_val;
        end
        if (ctrl.op == OP_TBL)
        begin
            ti_reg  <= exp_tbl[idx_ix];
            ti1_reg <= exp_tbl[idx_ix1];
        end
        if (ctrl.op == OP_SNAP)
        begin
            rsp_reg.gate         <= gate_reg;
            rsp_reg.pitch_hz     <= pitch_reg;
            rsp_reg.glide_now    <= gc_reg;
            rsp_reg.slide_now    <= sc_reg;
            rsp_reg.press_now    <= pc_reg;
            rsp_reg.strike_level <= strike_reg;
            rsp_reg.lift_level   <= lift_reg;
            rsp_reg.voice_age    <= 32'(age_reg);
        end
    end

endmodule

// File: bench/testbench.sv
// testbench: self-checking bench for mpe_voice_control_unit.
// Depends on mvc_pkg and the voice unit RTL. A built-in voice predictor checks
// every response word against expectations across several register settings.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import mvc_pkg::*;

    // index past the last register; the unit must ignore it
    localparam logic [1:0] CFG_UNUSED = 2'd3;
    localparam logic [31:0] AGE_FULL = 32'hFFFF_FFFF;
    localparam int TBL_SIZE = 256;
    localparam int STEP_Q8 = 3072;  // one octave in Q.8 semitones

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_word_t cmd_word = '0;
    logic rsp_valid;
    logic rsp_stall = 1'b0;
    rsp_word_t rsp_word;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = '0;
    logic [15:0] cfg_data = '0;

    always #1 clk = ~clk;

    mpe_voice_control_unit uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd_word  (cmd_word),
        .rsp_valid (rsp_valid),
        .rsp_stall (rsp_stall),
        .rsp_word  (rsp_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------
    // Voice predictor: registers, voice state and the Q30 exp2 table
    // ------------------------------------------------------------------
    logic [15:0] keep_share;
    logic [13:0] range_up;
    logic [13:0] range_down;

    logic              held;
    logic [6:0]        root;
    logic signed [15:0] strike, lift;
    logic signed [15:0] glide_cur, glide_tgt, slide_cur, slide_tgt, press_cur, press_tgt;
    logic [21:0]       hz_now;
    logic [31:0]       age;

    longint unsigned pow2_tbl [TBL_SIZE+1];

    cmd_word_t   pending_q[$];   // words waiting for the driver
    rsp_word_t   snapshot_q[$];  // predicted voice snapshots, oldest first
    int          errors = 0;
    longint      cycle_no = 0;

    // bitwise integer square root, floor
    function automatic longint unsigned root_floor(longint unsigned v);
        longint unsigned r, t;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            t = r | (64'd1 << b);
            if (t * t <= v)
                r = t;
        end
        return r;
    endfunction

    function automatic void fill_pow2();
        longint unsigned roots [8];
        longint unsigned v;
        roots[0] = root_floor(64'd1 << 61);
        for (int j = 1; j < 8; j++)
            roots[j] = root_floor(roots[j-1] << 30);
        for (int i = 0; i < TBL_SIZE; i++)
        begin
            v = 64'd1 << 30;
            for (int k = 0; k < 8; k++)
                if (i[k])
                    v = (v * roots[7-k] + (64'd1 << 29)) >> 30;
            pow2_tbl[i] = v;
        end
        pow2_tbl[TBL_SIZE] = 64'd1 << 31;
    endfunction

    function automatic logic signed [15:0] smooth(logic signed [15:0] cur,
                                                  logic signed [15:0] tgt);
        longint acc;
        acc = longint'(keep_share) * cur + (65536 - longint'(keep_share)) * tgt + 32768;
        acc = acc >>> 16;
        return acc[15:0];
    endfunction

    // note position plus bend to Hz in Q14.8
    function automatic logic [21:0] note_to_hz();
        longint bend, pos, e, q, r, s, idx, f;
        longint unsigned m, x;
        int sh;
        bend = longint'(glide_cur) * longint'(glide_cur > 0 ? range_up : range_down);
        bend = (bend + 16384) >>> 15;
        pos = longint'(root) * 256 + bend;
        if (pos > 127 * 256)
            return '0;
        e = pos - 69 * 256 + 13 * STEP_Q8;
        q = e / STEP_Q8 - 13;
        r = e % STEP_Q8;
        s = r * TBL_SIZE;
        idx = s / STEP_Q8;
        f = s % STEP_Q8;
        m = pow2_tbl[idx] + ((pow2_tbl[idx+1] - pow2_tbl[idx]) * f + 1536) / STEP_Q8;
        x = 64'd440 * 256 * m;
        sh = 30 - q;
        x = (x + (64'd1 << (sh - 1))) >> sh;
        if (x > 64'h3F_FFFF)
            x = 64'h3F_FFFF;
        return x[21:0];
    endfunction

    function automatic void voice_reset();
        keep_share = 16'd64880;
        range_up = 14'd512;
        range_down = 14'd512;
        held = 0; root = 0; strike = 0; lift = 0;
        glide_cur = 0; glide_tgt = 0; slide_cur = 0; slide_tgt = 0;
        press_cur = 0; press_tgt = 0;
        hz_now = 0;
        age = AGE_FULL;
    endfunction

    function automatic void voice_apply(cmd_word_t w);
        rsp_word_t snap;
        case (w.command)
            CMD_NOTE_ON:
            begin
                age = 0; held = 1; root = w.note; strike = w.value;
                hz_now = note_to_hz();
            end
            CMD_NOTE_OFF:
                if (held && w.note == root)
                begin
                    held = 0;
                    lift = w.value;
                end
            CMD_GLIDE: glide_tgt = w.value;
            CMD_SLIDE: slide_tgt = w.value;
            CMD_PRESS: press_tgt = w.value;
            CMD_TICK:
            begin
                glide_cur = smooth(glide_cur, glide_tgt);
                slide_cur = smooth(slide_cur, slide_tgt);
                press_cur = smooth(press_cur, press_tgt);
                hz_now = note_to_hz();
                if (age != AGE_FULL)
                    age = age + 1;
            end
            CMD_CLEAR:
            begin
                held = 0; strike = 0; lift = 0;
                glide_cur = 0; glide_tgt = 0; slide_cur = 0; slide_tgt = 0;
                press_cur = 0; press_tgt = 0;
                hz_now = 0; age = AGE_FULL;
            end
            default: ;  // unknown code leaves the voice alone
        endcase
        snap.gate = held;
        snap.pitch_hz = hz_now;
        snap.glide_now = glide_cur;
        snap.slide_now = slide_cur;
        snap.press_now = press_cur;
        snap.strike_level = strike;
        snap.lift_level = lift;
        snap.voice_age = age;
        snapshot_q.push_back(snap);
    endfunction

    task automatic report(string field, longint unsigned got, longint unsigned want);
        $display("%0t: mismatch on %s: got %h, expected %h", $realtime, field, got, want);
        errors++;
    endtask

    // ------------------------------------------------------------------
    // Traffic shaping: a calm window with no idling, and one long hold-off
    // ------------------------------------------------------------------
    logic calm, hold_off;
    always @(posedge clk)
        cycle_no <= cycle_no + 1;
    assign calm = (cycle_no >= 9000 && cycle_no < 13000);
    // receiver hold-off, counted here; the input side keeps offering words
    int hold_cnt = 0;
    always @(posedge clk)
    begin
        if (cycle_no == 4000)
            hold_cnt <= 400;
        else if (hold_cnt > 0)
            hold_cnt <= hold_cnt - 1;
    end
    assign hold_off = (hold_cnt > 0);

    // command driver: front of pending_q is the word on offer
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cmd_valid && !cmd_stall)
            begin
                voice_apply(pending_q.pop_front());
            end
            if (!(cmd_valid && cmd_stall))
            begin
                if (pending_q.size() > (cmd_valid && !cmd_stall ? 0 : 0) &&
                    (calm || $urandom_range(99) >= 11))
                begin
                    cmd_valid <= 1'b1;
                    cmd_word <= pending_q[0];
                end
                else
                begin
                    cmd_valid <= 1'b0;
                end
            end
        end
    end

    // response monitor
    always @(posedge clk)
    begin
        rsp_word_t want;
        if (rst_n)
        begin
            if (rsp_valid && !rsp_stall)
            begin
                if (snapshot_q.size() == 0)
                begin
                    $display("%0t: response word with nothing expected", $realtime);
                    errors++;
                end
                else
                begin
                    want = snapshot_q.pop_front();
                    if (rsp_word.gate !== want.gate)
                        report("gate", rsp_word.gate, want.gate);
                    if (rsp_word.pitch_hz !== want.pitch_hz)
                        report("pitch_hz", rsp_word.pitch_hz, want.pitch_hz);
                    if (rsp_word.glide_now !== want.glide_now)
                        report("glide_now", rsp_word.glide_now, want.glide_now);
                    if (rsp_word.slide_now !== want.slide_now)
                        report("slide_now", rsp_word.slide_now, want.slide_now);
                    if (rsp_word.press_now !== want.press_now)
                        report("press_now", rsp_word.press_now, want.press_now);
                    if (rsp_word.strike_level !== want.strike_level)
                        report("strike_level", rsp_word.strike_level, want.strike_level);
                    if (rsp_word.lift_level !== want.lift_level)
                        report("lift_level", rsp_word.lift_level, want.lift_level);
                    if (rsp_word.voice_age !== want.voice_age)
                        report("voice_age", rsp_word.voice_age, want.voice_age);
                end
            end
            rsp_stall <= hold_off || (!calm && $urandom_range(99) < 11);
        end
    end

    // ------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------
    function automatic cmd_word_t mk(cmd_code_t c, int n, int v);
        cmd_word_t w;
        w.command = c;
        w.note = n[6:0];
        w.value = v[15:0];
        return w;
    endfunction

    function automatic logic [15:0] rand_value();
        case ($urandom_range(7))
            0: return 16'h8000;
            1: return 16'h7FFF;
            2: return 16'h0000;
            default: return 16'($urandom());
        endcase
    endfunction

    logic [6:0] root_guess = 7'd60;

    // weighted random mix: note on, expression, ticks, note off matching the last note on half the time
    function automatic void queue_random(int count);
        cmd_word_t w;
        int pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(99);
            w.note = 7'($urandom());
            w.value = rand_value();
            if (pick < 10)
                w.command = CMD_NOTE_ON;
            else if (pick < 20)
            begin
                w.command = CMD_NOTE_OFF;
                if ($urandom_range(1) == 0)
                    w.note = root_guess;
            end
            else if (pick < 29) w.command = CMD_GLIDE;
            else if (pick < 36) w.command = CMD_SLIDE;
            else if (pick < 43) w.command = CMD_PRESS;
            else if (pick < 95) w.command = CMD_TICK;
            else if (pick < 98) w.command = CMD_CLEAR;
            else w.command = cmd_code_t'(3'd7);
            if (w.command == CMD_NOTE_ON)
                root_guess = w.note;
            pending_q.push_back(w);
        end
    endfunction

    // wait until the unit has returned every word, then let the clock run on before returning
    task automatic wait_idle();
        while (pending_q.size() != 0 || snapshot_q.size() != 0 || cmd_valid)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    // keeps cfg_valid high across back-to-back writes; caller lowers it
    task automatic cfg_write(logic [1:0] idx, logic [15:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= data;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        case (idx)
            CFG_SLEW_FACTOR: keep_share = data;
            CFG_BEND_UP:     range_up = data[13:0];
            CFG_BEND_DOWN:   range_down = data[13:0];
            default: ;
        endcase
    endtask

    task automatic set_regs(logic [15:0] s, logic [15:0] up, logic [15:0] dn);
        wait_idle();
        cfg_write(CFG_SLEW_FACTOR, s);
        cfg_write(CFG_BEND_UP, up);
        cfg_write(CFG_BEND_DOWN, dn);
        cfg_write(CFG_UNUSED, 16'($urandom()));
        cfg_valid <= 1'b0;
        @(negedge clk);
    endtask

    initial
    begin
        fill_pow2();
        voice_reset();
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // directed: field extremes, each command, the documented corner cases
        pending_q.push_back(mk(CMD_TICK, 0, 0));          // idle voice, age stays full
        pending_q.push_back(mk(CMD_NOTE_ON, 0, -32768));
        pending_q.push_back(mk(CMD_NOTE_OFF, 5, 1234));   // wrong note: ignored
        pending_q.push_back(mk(CMD_NOTE_OFF, 0, 32767));
        pending_q.push_back(mk(CMD_NOTE_OFF, 0, 77));     // gate already closed
        pending_q.push_back(mk(CMD_NOTE_ON, 127, 32767));
        pending_q.push_back(mk(CMD_GLIDE, 0, 32767));     // bend above note 127 -> 0 Hz
        pending_q.push_back(mk(CMD_TICK, 0, 0));
        pending_q.push_back(mk(CMD_TICK, 0, 0));
        pending_q.push_back(mk(CMD_SLIDE, 0, -32768));
        pending_q.push_back(mk(CMD_PRESS, 0, 32767));
        pending_q.push_back(mk(CMD_TICK, 0, 0));
        pending_q.push_back(mk(CMD_NOTE_ON, 0, 100));
        pending_q.push_back(mk(CMD_GLIDE, 0, -32768));    // deep downward bend
        pending_q.push_back(mk(CMD_TICK, 0, 0));
        pending_q.push_back(mk(CMD_TICK, 0, 0));
        pending_q.push_back(mk(cmd_code_t'(3'd7), 127, -1)); // unknown code
        pending_q.push_back(mk(CMD_CLEAR, 0, 0));          // root kept, rest zeroed
        pending_q.push_back(mk(CMD_NOTE_OFF, 0, 9));
        pending_q.push_back(mk(CMD_NOTE_ON, 69, 16384));   // A440 exactly
        pending_q.push_back(mk(CMD_TICK, 0, 0));
        queue_random(250);

        set_regs(16'd0, 16'd0, 16'd0);                 // no smoothing, no bend
        queue_random(250);
        set_regs(16'hFFFF, 16'd12288, 16'd12288);      // near-frozen slew, widest ranges
        queue_random(250);
        set_regs(16'd32768, 16'hFFFF, 16'd1);          // out-of-range up, tiny down
        queue_random(250);
        set_regs(16'($urandom()), 16'($urandom_range(12288)), 16'($urandom_range(12288)));
        queue_random(250);
        set_regs(16'd1, 16'd3, 16'h3FFF);
        queue_random(250);
        set_regs(16'd64880, 16'd512, 16'd512);         // back to the reset values
        queue_random(250);

        wait_idle();
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial
    begin
        #2ms;
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

endmodule

// File: mpe_voice_control_unit.f
sv/mvc_pkg.sv
sv/mvc_ctrl.sv
sv/mvc_datapath.sv
sv/mpe_voice_control_unit.sv
bench/testbench.sv
